### hw/rtl/ptm_pkg.sv
// Shared types, constants and index helpers for the two-level page table mapper.
package ptm_pkg;

  localparam int unsigned DIR_ENTRIES   = 1024;
  localparam int unsigned TABLE_ENTRIES = 1024;

  localparam int unsigned DIR_W    = $clog2(DIR_ENTRIES);
  localparam int unsigned TAB_W    = $clog2(TABLE_ENTRIES);
  localparam int unsigned PAGE_AW  = DIR_W + TAB_W;
  localparam int unsigned IDX_IN_W = 10;
  localparam int unsigned FRAME_W  = 20;
  localparam int unsigned FLAGS_W  = 2;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_W    = 11;
  localparam int unsigned CNT_W    = $clog2(TABLE_ENTRIES + 1);

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(768);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(TABLE_ENTRIES);

  localparam int unsigned RECIP_SHIFT = 2 * IDX_IN_W;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] DIR_RECIP =
    RECIP_W'((2 ** RECIP_SHIFT + DIR_ENTRIES - 1) / DIR_ENTRIES);
  localparam logic [RECIP_W-1:0] TAB_RECIP =
    RECIP_W'((2 ** RECIP_SHIFT + TABLE_ENTRIES - 1) / TABLE_ENTRIES);
  localparam logic [IDX_IN_W:0] DIR_N = (IDX_IN_W + 1)'(DIR_ENTRIES);
  localparam logic [IDX_IN_W:0] TAB_N = (IDX_IN_W + 1)'(TABLE_ENTRIES);

  typedef enum logic [CMD_W-1:0] {
    CMD_MAP        = 2'd0,
    CMD_UNMAP_FREE = 2'd1,
    CMD_UNMAP_KEEP = 2'd2,
    CMD_IGNORE     = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE       = 2'd0,
    STAT_MAPPED     = 2'd1,
    STAT_NOT_MAPPED = 2'd2
  } status_e;

  typedef struct packed {
    logic               present;
    logic               user;
    logic [FRAME_W-1:0] frame;
  } dir_entry_t;

  typedef struct packed {
    dir_entry_t       entry;
    logic [CNT_W-1:0] count;
  } dir_word_t;

  typedef struct packed {
    logic               present;
    logic               writable;
    logic               user;
    logic [FRAME_W-1:0] frame;
  } page_entry_t;

  typedef struct packed {
    status_e            status;
    logic               table_allocated;
    logic               page_freed;
    logic [FRAME_W-1:0] page_freed_frame;
    logic               table_freed;
    logic [FRAME_W-1:0] table_freed_frame;
    logic               invalidate;
  } result_t;

  typedef struct packed {
    logic        dir_we;
    dir_word_t   dir_wdata;
    logic        page_we;
    page_entry_t page_wdata;
    result_t     result;
  } upd_t;

  function automatic logic [IDX_IN_W-1:0] idx_quot(input logic [IDX_IN_W-1:0] x,
                                                   input logic [RECIP_W-1:0] recip);
    logic [IDX_IN_W+RECIP_W-1:0] prod;
    prod = {{RECIP_W{1'b0}}, x} * {{IDX_IN_W{1'b0}}, recip};
    return prod[RECIP_SHIFT +: IDX_IN_W];
  endfunction

  function automatic logic [IDX_IN_W-1:0] idx_rem(input logic [IDX_IN_W-1:0] x,
                                                  input logic [IDX_IN_W-1:0] q,
                                                  input logic [IDX_IN_W:0]   n);
    logic [2*IDX_IN_W:0] prod;
    prod = {{(IDX_IN_W + 1){1'b0}}, q} * {{IDX_IN_W{1'b0}}, n};
    return x - prod[IDX_IN_W-1:0];
  endfunction

endpackage

### hw/rtl/ptm_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module ptm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/ptm_update.sv
// Entry update and result logic for one map or unmap request.
module ptm_update (
  input  ptm_pkg::cmd_e                     cmd_i,
  input  logic [ptm_pkg::DIR_W-1:0]         dir_idx_i,
  input  logic [ptm_pkg::CFG_W-1:0]         user_first_i,
  input  logic [ptm_pkg::FRAME_W-1:0]       phys_frame_i,
  input  logic [ptm_pkg::FLAGS_W-1:0]       access_flags_i,
  input  logic [ptm_pkg::FRAME_W-1:0]       spare_frame_i,
  input  ptm_pkg::dir_word_t                dir_word_i,
  input  ptm_pkg::page_entry_t              page_i,
  output ptm_pkg::upd_t                     upd_o
);
  import ptm_pkg::*;

  logic [CFG_W-1:0] dir_idx_ext;
  logic [CNT_W-1:0] cnt_dec;

  assign dir_idx_ext = {{(CFG_W - DIR_W){1'b0}}, dir_idx_i};
  assign cnt_dec     = (dir_word_i.count != '0) ? dir_word_i.count - 1'b1 : '0;

  always_comb begin
    upd_o           = '0;
    upd_o.dir_wdata = dir_word_i;
    upd_o.result.status = STAT_DONE;
    case (cmd_i)
      CMD_MAP: begin
        if (!dir_word_i.entry.present) begin
          upd_o.dir_we                = 1'b1;
          upd_o.dir_wdata.entry.present = 1'b1;
          upd_o.dir_wdata.entry.user  = (dir_idx_ext >= user_first_i);
          upd_o.dir_wdata.entry.frame = spare_frame_i;
          upd_o.result.table_allocated = 1'b1;
        end
        if (page_i.present) begin
          upd_o.result.status = STAT_MAPPED;
        end else begin
          upd_o.page_we             = 1'b1;
          upd_o.page_wdata.present  = 1'b1;
          upd_o.page_wdata.writable = access_flags_i[0];
          upd_o.page_wdata.user     = access_flags_i[1];
          upd_o.page_wdata.frame    = phys_frame_i;
          upd_o.dir_we              = 1'b1;
          if (dir_word_i.count < CNT_MAX) begin
            upd_o.dir_wdata.count = dir_word_i.count + 1'b1;
          end
          upd_o.result.invalidate = 1'b1;
        end
      end
      CMD_UNMAP_FREE, CMD_UNMAP_KEEP: begin
        if (!dir_word_i.entry.present || !page_i.present) begin
          upd_o.result.status = STAT_NOT_MAPPED;
        end else begin
          if (cmd_i == CMD_UNMAP_FREE) begin
            upd_o.result.page_freed       = 1'b1;
            upd_o.result.page_freed_frame = page_i.frame;
          end
          upd_o.page_we           = 1'b1;
          upd_o.page_wdata        = '0;
          upd_o.result.invalidate = 1'b1;
          upd_o.dir_we            = 1'b1;
          upd_o.dir_wdata.count   = cnt_dec;
          if (cnt_dec == '0) begin
            upd_o.result.table_freed       = 1'b1;
            upd_o.result.table_freed_frame = dir_word_i.entry.frame;
            upd_o.dir_wdata                = '0;
          end
        end
      end
      default: begin
        upd_o.result.status = STAT_DONE;
      end
    endcase
  end

endmodule

### hw/rtl/two_level_page_table_mapper.sv
// Two-level page table mapper: request sequencer, directory and page entry memories.
//
// Requests arrive on in_valid_i/in_ready_o: a command (map, unmap and free
// the page frame, unmap and keep it), directory and table indexes, the frame
// and access flags to map, and a spare frame for a new page table. Each
// request gives exactly one result on out_valid_o/out_ready_i.
// The user boundary register is written on cfg_valid_i/cfg_ready_o; the
// port is always ready and takes writes at any time, the clearing pass too.
// A request passes through a read state, in which the directory word (entry
// and present count) and the page entry are read from their synchronous
// memories, and a write state, in which they are updated and written back and
// the result register is loaded. The next request is accepted in the write-back
// cycle, so a new request enters only once the last one reaches that state.
// After reset the block clears both memories, one address a cycle, through all
// 2**(DIR_W + TAB_W) page addresses (1048576 at 1024 by 1024 entries);
// in_ready_o stays low until that pass ends. If the receiver holds out_ready_i
// low the result is kept and the next request waits in its write-back cycle.
module two_level_page_table_mapper (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [ptm_pkg::CMD_W-1:0]        command_i,
  input  logic [ptm_pkg::IDX_IN_W-1:0]     dir_index_i,
  input  logic [ptm_pkg::IDX_IN_W-1:0]     table_index_i,
  input  logic [ptm_pkg::FRAME_W-1:0]      phys_frame_i,
  input  logic [ptm_pkg::FLAGS_W-1:0]      access_flags_i,
  input  logic [ptm_pkg::FRAME_W-1:0]      spare_table_frame_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ptm_pkg::CFG_W-1:0]        cfg_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [ptm_pkg::STATUS_W-1:0]     status_o,
  output logic                             table_allocated_o,
  output logic                             page_freed_o,
  output logic [ptm_pkg::FRAME_W-1:0]      page_freed_frame_o,
  output logic                             table_freed_o,
  output logic [ptm_pkg::FRAME_W-1:0]      table_freed_frame_o,
  output logic                             invalidate_o
);
  import ptm_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } state_e;

  state_e               state_q;
  logic [PAGE_AW-1:0]   clr_q;
  logic [CFG_W-1:0]     cfg_q;
  logic                 out_valid_q;
  result_t              result_q;

  cmd_e                 cmd_q;
  logic [IDX_IN_W-1:0]  dir_raw_q, tab_raw_q, dir_quot_q, tab_quot_q;
  logic [FRAME_W-1:0]   frame_q, spare_q;
  logic [FLAGS_W-1:0]   flags_q;
  logic [DIR_W-1:0]     di_q;
  logic [TAB_W-1:0]     ti_q;

  logic                 out_free, accept, advance, rd_en;
  logic [IDX_IN_W-1:0]  dir_rem, tab_rem;
  logic [DIR_W-1:0]     di_d;
  logic [TAB_W-1:0]     ti_d;

  logic                 dir_we, page_we;
  logic [DIR_W-1:0]     dir_waddr;
  logic [PAGE_AW-1:0]   page_waddr;
  dir_word_t            dir_wdata, dir_rdata;
  page_entry_t          page_wdata, page_rdata;
  upd_t                 upd;

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = (state_q == ST_WRITE) && out_free;
  assign in_ready_o = (state_q == ST_IDLE) || advance;
  assign accept     = in_valid_i && in_ready_o;
  assign rd_en      = (state_q == ST_READ);

  assign dir_rem = idx_rem(dir_raw_q, dir_quot_q, DIR_N);
  assign tab_rem = idx_rem(tab_raw_q, tab_quot_q, TAB_N);
  assign di_d    = dir_rem[DIR_W-1:0];
  assign ti_d    = tab_rem[TAB_W-1:0];

  ptm_update u_update (
    .cmd_i          (cmd_q),
    .dir_idx_i      (di_q),
    .user_first_i   (cfg_q),
    .phys_frame_i   (frame_q),
    .access_flags_i (flags_q),
    .spare_frame_i  (spare_q),
    .dir_word_i     (dir_rdata),
    .page_i         (page_rdata),
    .upd_o          (upd)
  );

  always_comb begin
    if (state_q == ST_CLEAR) begin
      dir_we     = 1'b1;
      dir_waddr  = clr_q[DIR_W-1:0];
      dir_wdata  = '0;
      page_we    = 1'b1;
      page_waddr = clr_q;
      page_wdata = '0;
    end else begin
      dir_we     = advance && upd.dir_we;
      dir_waddr  = di_q;
      dir_wdata  = upd.dir_wdata;
      page_we    = advance && upd.page_we;
      page_waddr = {di_q, ti_q};
      page_wdata = upd.page_wdata;
    end
  end

  ptm_ram #(
    .WIDTH ($bits(dir_word_t)),
    .DEPTH (2 ** DIR_W)
  ) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (dir_we),
    .waddr_i (dir_waddr),
    .wdata_i (dir_wdata),
    .re_i    (rd_en),
    .raddr_i (di_d),
    .rdata_o (dir_rdata)
  );

  ptm_ram #(
    .WIDTH ($bits(page_entry_t)),
    .DEPTH (2 ** PAGE_AW)
  ) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (page_we),
    .waddr_i (page_waddr),
    .wdata_i (page_wdata),
    .re_i    (rd_en),
    .raddr_i ({di_d, ti_d}),
    .rdata_o (page_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cfg_q       <= CFG_RESET;
      out_valid_q <= 1'b0;
      result_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        cfg_q <= cfg_data_i;
      end
      if (out_valid_q && out_ready_i && !advance) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_WRITE;
        end
        ST_WRITE: begin
          if (advance) begin
            out_valid_q <= 1'b1;
            result_q    <= upd.result;
            state_q     <= accept ? ST_READ : ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= cmd_e'(command_i);
      dir_raw_q  <= dir_index_i;
      tab_raw_q  <= table_index_i;
      dir_quot_q <= idx_quot(dir_index_i, DIR_RECIP);
      tab_quot_q <= idx_quot(table_index_i, TAB_RECIP);
      frame_q    <= phys_frame_i;
      flags_q    <= access_flags_i;
      spare_q    <= spare_table_frame_i;
    end
    if (rd_en) begin
      di_q <= di_d;
      ti_q <= ti_d;
    end
  end

  assign cfg_ready_o         = 1'b1;
  assign out_valid_o         = out_valid_q;
  assign status_o            = result_q.status;
  assign table_allocated_o   = result_q.table_allocated;
  assign page_freed_o        = result_q.page_freed;
  assign page_freed_frame_o  = result_q.page_freed_frame;
  assign table_freed_o       = result_q.table_freed;
  assign table_freed_frame_o = result_q.table_freed_frame;
  assign invalidate_o        = result_q.invalidate;

endmodule

### bench/tb_two_level_page_table_mapper.sv
// Self-checking bench for the two-level page table mapper: directed table, random traffic.
`timescale 1ns / 100ps

module tb_two_level_page_table_mapper;
  import ptm_pkg::*;

  typedef struct packed {
    cmd_e                cmd;
    logic [IDX_IN_W-1:0] dir;
    logic [IDX_IN_W-1:0] tab;
    logic [FRAME_W-1:0]  frame;
    logic [FLAGS_W-1:0]  flags;
    logic [FRAME_W-1:0]  spare;
  } page_request_t;

  typedef struct {
    page_request_t req;
    logic          has_want;
    result_t       want;
  } directed_row_t;

  localparam int unsigned N_DIRECTED  = 22;
  localparam int unsigned PHASE_ITEMS = 500;
  localparam int unsigned HOLD_CYCLES = 300;

  logic                clk_i               = 1'b0;
  logic                rst_ni              = 1'b0;
  logic                in_valid_i          = 1'b0;
  logic                in_ready_o;
  logic [CMD_W-1:0]    command_i           = '0;
  logic [IDX_IN_W-1:0] dir_index_i         = '0;
  logic [IDX_IN_W-1:0] table_index_i       = '0;
  logic [FRAME_W-1:0]  phys_frame_i        = '0;
  logic [FLAGS_W-1:0]  access_flags_i      = '0;
  logic [FRAME_W-1:0]  spare_table_frame_i = '0;
  logic                cfg_valid_i         = 1'b0;
  logic                cfg_ready_o;
  logic [CFG_W-1:0]    cfg_data_i          = '0;
  logic                out_valid_o;
  logic                out_ready_i         = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic                table_allocated_o;
  logic                page_freed_o;
  logic [FRAME_W-1:0]  page_freed_frame_o;
  logic                table_freed_o;
  logic [FRAME_W-1:0]  table_freed_frame_o;
  logic                invalidate_o;

  dir_entry_t    directory [DIR_ENTRIES];
  page_entry_t   page_map [int unsigned];
  int unsigned   present_count [DIR_ENTRIES];
  logic [CFG_W-1:0] user_boundary = CFG_RESET;

  result_t       mapping_outcomes [$];
  int unsigned   mismatches    = 0;
  int unsigned   results_taken = 0;
  int unsigned   next_hold_at  = 150;
  int unsigned   hold_left     = 0;
  int unsigned   stall_mode    = 0;
  int unsigned   stall_phase   = 0;
  int unsigned   burst_left    = 0;
  result_t       observed;
  result_t       awaited;

  directed_row_t directed_rows [N_DIRECTED] = '{
    '{'{CMD_UNMAP_FREE, 10'd0, 10'd0, 20'h00000, 2'd0, 20'h00000},
      1'b1, '{STAT_NOT_MAPPED, 1'b0, 1'b0, 20'h00000, 1'b0, 20'h00000, 1'b0}},
    '{'{CMD_UNMAP_KEEP, 10'd1023, 10'd1023, 20'h00000, 2'd0, 20'h00000},
      1'b1, '{STAT_NOT_MAPPED, 1'b0, 1'b0, 20'h00000, 1'b0, 20'h00000, 1'b0}},
    '{'{CMD_IGNORE, 10'd5, 10'd5, 20'hFFFFF, 2'd3, 20'hFFFFF},
      1'b1, '{STAT_DONE, 1'b0, 1'b0, 20'h00000, 1'b0, 20'h00000, 1'b0}},
    '{'{CMD_MAP, 10'd0, 10'd0, 20'h00000, 2'd0, 20'h00001},
      1'b1, '{STAT_DONE, 1'b1, 1'b0, 20'h00000, 1'b0, 20'h00000, 1'b1}},
    '{'{CMD_MAP, 10'd0, 10'd0, 20'h12345, 2'd1, 20'hFFFFF},
      1'b1, '{STAT_MAPPED, 1'b0, 1'b0, 20'h00000, 1'b0, 20'h00000, 1'b0}},
    '{'{CMD_MAP, 10'd0, 10'd1023, 20'hFFFFF, 2'd3, 20'hABCDE},
      1'b1, '{STAT_DONE, 1'b0, 1'b0, 20'h00000, 1'b0, 20'h00000, 1'b1}},
    '{'{CMD_UNMAP_KEEP, 10'd0, 10'd0, 20'h00000, 2'd0, 20'h00000},
      1'b1, '{STAT_DONE, 1'b0, 1'b0, 20'h00000, 1'b0, 20'h00000, 1'b1}},
    '{'{CMD_UNMAP_FREE, 10'd0, 10'd0, 20'h00000, 2'd0, 20'h00000},
      1'b1, '{STAT_NOT_MAPPED, 1'b0, 1'b0, 20'h00000, 1'b0, 20'h00000, 1'b0}},
    '{'{CMD_UNMAP_FREE, 10'd0, 10'd1023, 20'h00000, 2'd0, 20'h00000},
      1'b1, '{STAT_DONE, 1'b0, 1'b1, 20'hFFFFF, 1'b1, 20'h00001, 1'b1}},
    '{'{CMD_UNMAP_KEEP, 10'd0, 10'd1023, 20'h00000, 2'd0, 20'h00000},
      1'b1, '{STAT_NOT_MAPPED, 1'b0, 1'b0, 20'h00000, 1'b0, 20'h00000, 1'b0}},
    '{'{CMD_MAP, 10'd1023, 10'd1023, 20'hFFFFF, 2'd3, 20'hFFFFF},
      1'b1, '{STAT_DONE, 1'b1, 1'b0, 20'h00000, 1'b0, 20'h00000, 1'b1}},
    '{'{CMD_MAP, 10'd767, 10'd512, 20'h55555, 2'd1, 20'hAAAAA},
      1'b1, '{STAT_DONE, 1'b1, 1'b0, 20'h00000, 1'b0, 20'h00000, 1'b1}},
    '{'{CMD_MAP, 10'd768, 10'd0, 20'hAAAAA, 2'd2, 20'h55555},
      1'b1, '{STAT_DONE, 1'b1, 1'b0, 20'h00000, 1'b0, 20'h00000, 1'b1}},
    '{'{CMD_IGNORE, 10'd1023, 10'd1023, 20'hFFFFF, 2'd3, 20'hFFFFF},
      1'b1, '{STAT_DONE, 1'b0, 1'b0, 20'h00000, 1'b0, 20'h00000, 1'b0}},
    '{'{CMD_MAP, 10'd1023, 10'd1023, 20'h00000, 2'd0, 20'h00000},
      1'b1, '{STAT_MAPPED, 1'b0, 1'b0, 20'h00000, 1'b0, 20'h00000, 1'b0}},
    '{'{CMD_UNMAP_KEEP, 10'd1023, 10'd1023, 20'h00000, 2'd0, 20'h00000},
      1'b1, '{STAT_DONE, 1'b0, 1'b0, 20'h00000, 1'b1, 20'hFFFFF, 1'b1}},
    '{'{CMD_UNMAP_FREE, 10'd767, 10'd512, 20'h00000, 2'd0, 20'h00000},
      1'b1, '{STAT_DONE, 1'b0, 1'b1, 20'h55555, 1'b1, 20'hAAAAA, 1'b1}},
    '{'{CMD_UNMAP_FREE, 10'd768, 10'd0, 20'h00000, 2'd0, 20'h00000},
      1'b1, '{STAT_DONE, 1'b0, 1'b1, 20'hAAAAA, 1'b1, 20'h55555, 1'b1}},
    '{'{CMD_MAP, 10'd512, 10'd7, 20'h0F0F0, 2'd2, 20'h3C3C3}, 1'b0, '0},
    '{'{CMD_MAP, 10'd512, 10'd8, 20'hF0F0F, 2'd1, 20'hC3C3C}, 1'b0, '0},
    '{'{CMD_UNMAP_FREE, 10'd512, 10'd7, 20'h00000, 2'd0, 20'h00000}, 1'b0, '0},
    '{'{CMD_UNMAP_KEEP, 10'd512, 10'd8, 20'h00000, 2'd0, 20'h00000}, 1'b0, '0}
  };

  two_level_page_table_mapper dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic result_t apply_page_request(input page_request_t req);
    result_t     res;
    page_entry_t pe;
    int unsigned di;
    int unsigned ti;
    int unsigned key;
    res        = '0;
    res.status = STAT_DONE;
    di  = req.dir % DIR_ENTRIES;
    ti  = req.tab % TABLE_ENTRIES;
    key = di * TABLE_ENTRIES + ti;
    pe  = page_map.exists(key) ? page_map[key] : '0;
    case (req.cmd)
      CMD_MAP: begin
        if (!directory[di].present) begin
          directory[di]       = '{1'b1, di >= user_boundary, req.spare};
          res.table_allocated = 1'b1;
        end
        if (pe.present) begin
          res.status = STAT_MAPPED;
        end else begin
          page_map[key] = '{1'b1, req.flags[0], req.flags[1], req.frame};
          if (present_count[di] < TABLE_ENTRIES) present_count[di]++;
          res.invalidate = 1'b1;
        end
      end
      CMD_UNMAP_FREE, CMD_UNMAP_KEEP: begin
        if (!directory[di].present || !pe.present) begin
          res.status = STAT_NOT_MAPPED;
        end else begin
          if (req.cmd == CMD_UNMAP_FREE) begin
            res.page_freed       = 1'b1;
            res.page_freed_frame = pe.frame;
          end
          page_map.delete(key);
          res.invalidate = 1'b1;
          if (present_count[di] > 0) present_count[di]--;
          if (present_count[di] == 0) begin
            res.table_freed       = 1'b1;
            res.table_freed_frame = directory[di].frame;
            directory[di]         = '0;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  task automatic send_request(input page_request_t req, input logic has_want,
                              input result_t want);
    result_t predicted;
    in_valid_i          <= 1'b1;
    command_i           <= req.cmd;
    dir_index_i         <= req.dir;
    table_index_i       <= req.tab;
    phys_frame_i        <= req.frame;
    access_flags_i      <= req.flags;
    spare_table_frame_i <= req.spare;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = apply_page_request(req);
    mapping_outcomes.push_back(has_want ? want : predicted);
  endtask

  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(8, 20)) @(posedge clk_i);
      else repeat ($urandom_range(1, 4)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (mapping_outcomes.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_user_boundary(input logic [CFG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i   <= 1'b0;
    user_boundary  = value;
  endtask

  // Result capture and receiver stall pattern, with long hold-offs to back up the input.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      observed = '{status_e'(status_o), table_allocated_o, page_freed_o, page_freed_frame_o,
                   table_freed_o, table_freed_frame_o, invalidate_o};
      results_taken++;
      if (mapping_outcomes.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
      end else begin
        awaited = mapping_outcomes.pop_front();
        check_field("status", observed.status, awaited.status);
        check_field("table_allocated", observed.table_allocated, awaited.table_allocated);
        check_field("page_freed", observed.page_freed, awaited.page_freed);
        check_field("page_freed_frame", observed.page_freed_frame, awaited.page_freed_frame);
        check_field("table_freed", observed.table_freed, awaited.table_freed);
        check_field("table_freed_frame", observed.table_freed_frame,
                    awaited.table_freed_frame);
        check_field("invalidate", observed.invalidate, awaited.invalidate);
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (results_taken >= next_hold_at) begin
      hold_left     = HOLD_CYCLES;
      next_hold_at += 1000;
      out_ready_i  <= 1'b0;
    end else begin
      if (stall_phase == 0) begin
        stall_mode  = $urandom_range(0, 3);
        stall_phase = $urandom_range(16, 80);
      end else begin
        stall_phase--;
      end
      case (stall_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        2:       out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  initial begin
    page_request_t       req;
    logic [IDX_IN_W-1:0] dir_pool [4];
    logic [IDX_IN_W-1:0] tab_pool [6];
    logic [CFG_W-1:0]    boundaries [4];
    int unsigned         counted;
    int unsigned         pick;
    foreach (directory[i]) begin
      directory[i]     = '0;
      present_count[i] = 0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].has_want, directed_rows[i].want);
      pace_sender();
    end

    boundaries = '{CFG_W'(1024), CFG_W'(0), CFG_W'($urandom_range(1, 1023)), CFG_W'(1023)};
    for (int phase = 0; phase < 4; phase++) begin
      drain_requests();
      write_user_boundary(boundaries[phase]);
      dir_pool[0] = phase[0] ? 10'd1023 : 10'd0;
      for (int i = 1; i < 4; i++) dir_pool[i] = IDX_IN_W'($urandom_range(0, 1023));
      tab_pool[0] = 10'd0;
      tab_pool[1] = 10'd1023;
      for (int i = 2; i < 6; i++) tab_pool[i] = IDX_IN_W'($urandom_range(0, 1023));
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 85) begin
          req.dir = dir_pool[$urandom_range(0, 3)];
          req.tab = tab_pool[$urandom_range(0, 5)];
          pick    = $urandom_range(0, 99);
          req.cmd = (pick < 50) ? CMD_MAP :
                    (pick < 75) ? CMD_UNMAP_FREE :
                    (pick < 97) ? CMD_UNMAP_KEEP : CMD_IGNORE;
        end else begin
          req.dir = IDX_IN_W'($urandom_range(0, 1023));
          req.tab = IDX_IN_W'($urandom_range(0, 1023));
          req.cmd = cmd_e'($urandom_range(0, 3));
        end
        req.frame = FRAME_W'($urandom_range(0, 20'hFFFFF));
        req.flags = FLAGS_W'($urandom_range(0, 3));
        req.spare = FRAME_W'($urandom_range(0, 20'hFFFFF));
        send_request(req, 1'b0, '0);
        if (req.cmd != CMD_IGNORE) counted++;
        pace_sender();
      end
    end

    drain_requests();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("two_level_page_table_mapper verification clean");
    end else begin
      $display("two_level_page_table_mapper verification failed");
    end
    $finish;
  end

  // Allow for the memory clearing pass after reset plus the whole traffic run.
  initial begin
    #(40_000_000);
    $display("two_level_page_table_mapper verification failed");
    $finish;
  end

endmodule
